FILE: sv/mhfb_pkg.sv
package mhfb_pkg;

  localparam int MAC_W    = 48;
  localparam int CRC_W    = 32;
  localparam int IDX_W    = 6;
  localparam int TABLE_W  = 64;
  localparam int BYTE_W   = 8;
  localparam int MAC_BYTES = MAC_W / BYTE_W;

  localparam logic [CRC_W-1:0]   CRC_INIT     = 32'hFFFF_FFFF;
  // 0x04C11DB6 with bit 0 set, the standard ethernet polynomial
  localparam logic [CRC_W-1:0]   CRC_POLY     = 32'h04C1_1DB7;
  // broadcast word 0x8000 in the top 16-bit word of the table
  localparam logic [TABLE_W-1:0] TABLE_BCAST  = {16'h8000, 48'h0};

  typedef enum logic {
    REQ_CLEAR = 1'b0,
    REQ_ADD   = 1'b1
  } req_t;

  typedef struct packed {
    req_t             req;
    logic [IDX_W-1:0] hash_index;
    logic             list_done;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  // one byte of the crc, lsb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = c[CRC_W-1] ^ data[i];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  // crc bit 0 becomes index bit 5
  function automatic logic [IDX_W-1:0] rev_low6(input logic [CRC_W-1:0] crc);
    logic [IDX_W-1:0] r;
    for (int i = 0; i < IDX_W; i++) begin
      r[IDX_W-1-i] = crc[i];
    end
    return r;
  endfunction

endpackage

FILE: sv/multicast_hash_filter_builder.sv
// multicast hash filter builder: keeps a 64-bit ethernet multicast hash table
// request channel: start/busy command handshake; a request transfers at a
// rising edge with start high and busy low, carrying req_type, mac_address
// and last_in_list
// result channel: done strobes for exactly one cycle with hash_index,
// filter_table (table after the update) and list_done; the receiver cannot
// stall, every result transfers at the edge that ends the done cycle
// path: an add request passes the crc state, the push state, the queue
// and the result register; a clear request skips the crc state
// pacing: the front is busy until the request is pushed, then takes the next
// while the back finishes; its crc unit folds one address byte per cycle
// structure: front (accept, crc, index) -> short queue -> back (table update)
// reset: synchronous rst empties the queue, returns the front to idle, drops
// done and clears the whole table to zero (broadcast bit included)
module multicast_hash_filter_builder #(
  parameter int QUEUE_DEPTH = 2  // range 2 and up
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [47:0] mac_address,
  input  logic        last_in_list,
  // result channel
  output logic        done,
  output logic [5:0]  hash_index,
  output logic [63:0] filter_table,
  output logic        list_done
);
  import mhfb_pkg::*;

  // front to queue
  q_push_t  push;
  logic     q_full;
  // queue to back
  logic     q_empty;
  logic     pop;
  q_entry_t head;

  // front: takes the request, hashes the address byte by byte
  mhfb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .mac_address  (mac_address),
    .last_in_list (last_in_list),
    .q_full       (q_full),
    .push         (push)
  );

  // short queue decoupling hash from table update
  mhfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (head)
  );

  // back: applies clear or set-bit, registers the result
  mhfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .hash_index   (hash_index),
    .filter_table (filter_table),
    .list_done    (list_done)
  );

endmodule

FILE: sv/mhfb_front.sv
module mhfb_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type,
  input  logic [47:0]             mac_address,
  input  logic                    last_in_list,
  input  logic                    q_full,
  output mhfb_pkg::q_push_t       push
);
  import mhfb_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CRC  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  localparam logic [2:0] LAST_BYTE = 3'(MAC_BYTES - 1);

  fstate_t          state;
  fstate_t          state_next;
  logic [MAC_W-1:0] mac_sr;
  logic [CRC_W-1:0] crc;
  logic [CRC_W-1:0] crc_next;
  logic [2:0]       byte_cnt;
  q_entry_t         entry;

  assign crc_next = crc_byte(crc, mac_sr[BYTE_W-1:0]);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (start) begin
          state_next = (req_t'(req_type) == REQ_ADD) ? F_CRC : F_PUSH;
        end
      end
      F_CRC: begin
        if (byte_cnt == LAST_BYTE) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        mac_sr               <= mac_address;
        crc                  <= CRC_INIT;
        byte_cnt             <= '0;
        entry.req            <= req_t'(req_type);
        entry.hash_index     <= '0;
        entry.list_done      <= last_in_list;
      end
      F_CRC: begin
        mac_sr   <= mac_sr >> BYTE_W;
        crc      <= crc_next;
        byte_cnt <= byte_cnt + 3'd1;
        if (byte_cnt == LAST_BYTE) begin
          entry.hash_index <= rev_low6(crc_next);
        end
      end
      default: begin
      end
    endcase
  end

  assign busy        = (state != F_IDLE);
  assign push.valid  = (state == F_PUSH) && !q_full;
  assign push.entry  = entry;

endmodule

FILE: sv/mhfb_queue.sv
module mhfb_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  mhfb_pkg::q_push_t   push,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output mhfb_pkg::q_entry_t  head
);
  import mhfb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/mhfb_back.sv
module mhfb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mhfb_pkg::q_entry_t  head,
  output logic                pop,
  output logic                done,
  output logic [5:0]          hash_index,
  output logic [63:0]         filter_table,
  output logic                list_done
);
  import mhfb_pkg::*;

  logic [TABLE_W-1:0] table_bits;
  logic [TABLE_W-1:0] table_next;

  assign pop = !q_empty;

  always_comb begin
    case (head.req)
      REQ_CLEAR: table_next = TABLE_BCAST;
      REQ_ADD:   table_next = table_bits | (TABLE_W'(1) << head.hash_index);
      default:   table_next = table_bits;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bits <= '0;
      done       <= 1'b0;
    end else begin
      done <= pop;
      if (pop) begin
        table_bits <= table_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hash_index <= head.hash_index;
      list_done  <= head.list_done;
    end
  end

  assign filter_table = table_bits;

endmodule

FILE: sv/mhfb_checker.sv
module mhfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [5:0]  hash_index,
  input logic [63:0] filter_table
);

  // an accepted request always holds the port busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request transfer");

  // the table only moves together with a result
  a_table_stable: assert property (@(posedge clk) disable iff (rst)
    !done && !$past(rst) |-> $stable(filter_table))
    else $error("filter table changed without a result");

  // broadcast bit, once set, stays set until reset
  a_bcast_sticky: assert property (@(posedge clk) disable iff (rst)
    filter_table[63] |=> filter_table[63])
    else $error("broadcast bit dropped");

  // while the broadcast bit is low no clear came since reset, so every result is an add and its bit is set
  a_index_set: assert property (@(posedge clk) disable iff (rst)
    done && !filter_table[63] |-> filter_table[hash_index])
    else $error("hashed bit not set in table");

endmodule

bind multicast_hash_filter_builder mhfb_checker u_mhfb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .hash_index   (hash_index),
  .filter_table (filter_table)
);
